/* rtl/mlfq_thread_scheduler_macros.svh */
// Assertion helpers shared by the scheduler modules.
// Both expect the enclosing module to have clk and rst_n.
`ifndef MLFQ_THREAD_SCHEDULER_MACROS_SVH
`define MLFQ_THREAD_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define MLFQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlfq scheduler assertion failed");

// Next-cycle implication.
`define MLFQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlfq scheduler assertion failed");

`endif

/* rtl/mlfq_pkg.sv */
package mlfq_pkg;

  localparam int TID_W  = 5;
  localparam int PRIO_W = 2;
  localparam int CNT_W  = 16;

  localparam logic [CNT_W-1:0] BOOST_RESET = 16'd50;

  // Operation codes.
  localparam logic [1:0] FUNC_ENQ  = 2'd0;
  localparam logic [1:0] FUNC_DEQ  = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [TID_W-1:0]  thread_id;
    logic              set_priority;
    logic [PRIO_W-1:0] new_priority;
    logic              current_valid;
    logic [TID_W-1:0]  current_id;
  } in_t;

  typedef struct packed {
    logic [TID_W-1:0] out_thread;
    logic             found;
    logic             boosted;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic walk;
    logic link;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic boost_fire;
    logic scan_done;
    logic level_ne;
    logic at_tail;
  } sts_t;

endpackage

/* rtl/mlfq_thread_scheduler.sv */
// Channel   | Ports                          | Beat taken when
// ----------+--------------------------------+-------------------------------
// command   | start, busy, in_data           | start high and busy low
// result    | out_valid, out_data            | out_valid high (one cycle)
// config    | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//
// Enqueue, dequeue and a tick without boost pass through the accept cycle,
// which also issues the reads of the link and level memories, and the execute
// state; the result beat follows, and a new command may be taken in that cycle.
// A boosting tick then scans each lower level and walks it through the link
// memory, whose registered read needs a WALK and a LINK state per hop, before
// its result is given.
// Reset (rst_n low, synchronous) empties all queues, clears the tick count
// and all stored levels, and sets the boost interval to 50; no clearing pass.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
// The configuration port is always ready and is meant to be written only idle.

module mlfq_thread_scheduler
  import mlfq_pkg::*;
#(
  parameter int LEVELS      = 3,
  parameter int MAX_THREADS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_data,
  output logic             out_valid,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // The boost interval register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences accept, execute and the boost walk.
  mlfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // The datapath holds the queue lists, the level store and the tick counter.
  mlfq_datapath #(
    .LEVELS      (LEVELS),
    .MAX_THREADS (MAX_THREADS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule

/* rtl/mlfq_ctrl.sv */
`include "mlfq_thread_scheduler_macros.svh"

module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EXEC = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_WALK = 5'b01000,
    ST_LINK = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.capture = start;
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.boost_fire) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.level_ne) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk  = 1'b1;
        state_nxt = sts.at_tail ? ST_SCAN : ST_LINK;
      end
      ST_LINK: begin
        cmd.link  = 1'b1;
        state_nxt = ST_WALK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // A result always returns the controller to idle.
  `MLFQ_ASSERT_NXT(a_emit_then_idle, cmd.emit, state_r == ST_IDLE)

endmodule

/* rtl/mlfq_datapath.sv */
`include "mlfq_thread_scheduler_macros.svh"

module mlfq_datapath
  import mlfq_pkg::*;
#(
  parameter int LEVELS      = 3,
  parameter int MAX_THREADS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_t              in_data,
  input  logic             cfg_valid,
  input  logic [CNT_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output out_t             out_data,
  output logic             out_valid
);

  localparam int TW   = $clog2(MAX_THREADS);
  localparam int LW   = $clog2(LEVELS);
  localparam int LCW  = $clog2(LEVELS + 1);
  localparam int LTOP = LEVELS - 1;

  // Captured operation and configuration.
  in_t              in_q_r;
  logic [CNT_W-1:0] bi_r;
  logic [CNT_W-1:0] tick_r;

  // Queue bookkeeping.
  logic [TW-1:0]          head_r [LEVELS];
  logic [TW-1:0]          tail_r [LEVELS];
  logic [LEVELS-1:0]      ne_r;
  logic [MAX_THREADS-1:0] queued_r;
  logic [MAX_THREADS-1:0] tl_vld_r;

  // Link and level memories with registered reads.
  logic [TW-1:0] nl_mem [MAX_THREADS];
  logic [LW-1:0] tl_mem [MAX_THREADS];
  logic [TW-1:0] nl_rd_r;
  logic [LW-1:0] tl_rd_r;
  logic          tl_rd_vld_r;

  // Boost walk.
  logic [LCW-1:0] blvl_r, blvl_nxt;
  logic [TW-1:0]  node_r, node_nxt;

  out_t out_r, out_nxt;
  logic out_valid_r;

  logic [LW-1:0]    dlvl;
  logic             any_ne;
  logic [TW-1:0]    nl_raddr, tl_raddr;
  logic [TW-1:0]    tid_a, cid_a, deq_h;
  logic [LW-1:0]    lvl_mem, newp_lvl, enq_lvl, scan_lvl;
  logic             enq_ok, cur_ok, is_tick, demote, boost_fire, deq_last, do_deq;
  logic             scan_done, level_ne, at_tail;
  logic [CNT_W-1:0] tick_inc;

  logic          tl_we, nl_we;
  logic [TW-1:0] tl_waddr, nl_waddr, nl_wdata;
  logic [LW-1:0] tl_wdata;

  // Highest-priority non-empty level.
  always_comb begin
    dlvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (ne_r[i]) begin
        dlvl = LW'(i);
      end
    end
  end
  assign any_ne = |ne_r;

  assign nl_raddr = cmd.walk ? node_r : head_r[dlvl];
  assign tl_raddr = (in_data.func == FUNC_TICK) ? TW'(in_data.current_id)
                                                : TW'(in_data.thread_id);

  assign tid_a    = TW'(in_q_r.thread_id);
  assign cid_a    = TW'(in_q_r.current_id);
  assign lvl_mem  = tl_rd_vld_r ? tl_rd_r : '0;
  assign newp_lvl = (32'(in_q_r.new_priority) > LTOP) ? LW'(LTOP)
                                                     : LW'(in_q_r.new_priority);
  assign enq_lvl  = in_q_r.set_priority ? newp_lvl : lvl_mem;
  assign enq_ok   = (in_q_r.func == FUNC_ENQ) && (32'(in_q_r.thread_id) < MAX_THREADS)
                    && !queued_r[tid_a];
  assign cur_ok   = in_q_r.current_valid && (32'(in_q_r.current_id) < MAX_THREADS);
  assign is_tick  = (in_q_r.func == FUNC_TICK);
  assign tick_inc = tick_r + CNT_W'(1);
  assign boost_fire = is_tick && (tick_inc >= bi_r);
  assign demote   = is_tick && cur_ok && (in_q_r.current_id != '0)
                    && (32'(lvl_mem) < LTOP);
  assign deq_h    = head_r[dlvl];
  assign deq_last = (deq_h == tail_r[dlvl]);
  assign do_deq   = cmd.exec && (in_q_r.func == FUNC_DEQ) && any_ne;

  assign scan_lvl  = blvl_r[LW-1:0];
  assign scan_done = (32'(blvl_r) >= LEVELS);
  assign level_ne  = !scan_done && ne_r[scan_lvl];
  assign at_tail   = (node_r == tail_r[scan_lvl]);

  always_comb begin
    sts            = '0;
    sts.boost_fire = boost_fire;
    sts.scan_done  = scan_done;
    sts.level_ne   = level_ne;
    sts.at_tail    = at_tail;
  end

  // Memory write ports.
  always_comb begin
    tl_we    = 1'b0;
    tl_waddr = tid_a;
    tl_wdata = enq_lvl;
    nl_we    = 1'b0;
    nl_waddr = tail_r[enq_lvl];
    nl_wdata = tid_a;
    if (cmd.exec) begin
      if (enq_ok) begin
        tl_we = 1'b1;
        nl_we = ne_r[enq_lvl];
      end else if (is_tick && cur_ok && (boost_fire || demote)) begin
        tl_we    = 1'b1;
        tl_waddr = cid_a;
        tl_wdata = boost_fire ? '0 : (lvl_mem + LW'(1));
      end
    end else if (cmd.walk) begin
      tl_we    = 1'b1;
      tl_waddr = node_r;
      tl_wdata = '0;
      nl_we    = at_tail && ne_r[0];
      nl_waddr = tail_r[0];
      nl_wdata = head_r[scan_lvl];
    end
  end

  always_ff @(posedge clk) begin
    if (tl_we) begin
      tl_mem[tl_waddr] <= tl_wdata;
    end
    if (nl_we) begin
      nl_mem[nl_waddr] <= nl_wdata;
    end
    nl_rd_r     <= nl_mem[nl_raddr];
    tl_rd_r     <= tl_mem[tl_raddr];
    tl_rd_vld_r <= tl_vld_r[tl_raddr];
  end

  // Walk position.
  always_comb begin
    blvl_nxt = blvl_r;
    node_nxt = node_r;
    if (cmd.exec) begin
      blvl_nxt = LCW'(1);
    end else if (cmd.scan) begin
      if (level_ne) begin
        node_nxt = head_r[scan_lvl];
      end else if (!scan_done) begin
        blvl_nxt = blvl_r + LCW'(1);
      end
    end else if (cmd.walk && at_tail) begin
      blvl_nxt = blvl_r + LCW'(1);
    end else if (cmd.link) begin
      node_nxt = nl_rd_r;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (cmd.scan) begin
      out_nxt.boosted = 1'b1;
    end else if (do_deq) begin
      out_nxt.out_thread = TID_W'(deq_h);
      out_nxt.found      = 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    blvl_r <= blvl_nxt;
    node_r <= node_nxt;
    if (cmd.capture) begin
      in_q_r <= in_data;
    end
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
    if (cmd.exec && enq_ok) begin
      if (!ne_r[enq_lvl]) begin
        head_r[enq_lvl] <= tid_a;
      end
      tail_r[enq_lvl] <= tid_a;
    end else if (do_deq && !deq_last) begin
      head_r[dlvl] <= nl_rd_r;
    end else if (cmd.walk && at_tail) begin
      if (!ne_r[0]) begin
        head_r[0] <= head_r[scan_lvl];
      end
      tail_r[0] <= tail_r[scan_lvl];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bi_r        <= BOOST_RESET;
      tick_r      <= '0;
      ne_r        <= '0;
      queued_r    <= '0;
      tl_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_valid) begin
        bi_r <= cfg_data;
      end
      if (cmd.exec && is_tick) begin
        tick_r <= boost_fire ? '0 : tick_inc;
      end
      if (tl_we) begin
        tl_vld_r[tl_waddr] <= 1'b1;
      end
      if (cmd.exec && enq_ok) begin
        ne_r[enq_lvl]   <= 1'b1;
        queued_r[tid_a] <= 1'b1;
      end else if (do_deq) begin
        queued_r[deq_h] <= 1'b0;
        if (deq_last) begin
          ne_r[dlvl] <= 1'b0;
        end
      end else if (cmd.walk && at_tail) begin
        ne_r[scan_lvl] <= 1'b0;
        ne_r[0]        <= 1'b1;
      end
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // A popped thread is no longer marked as queued.
  `MLFQ_ASSERT_IMP(a_popped_not_queued, out_valid_r && out_r.found,
                   !queued_r[TW'(out_r.out_thread)])
  // After a boost only the top level may hold threads.
  `MLFQ_ASSERT_IMP(a_boost_empties_lower, out_valid_r && out_r.boosted,
                   (ne_r >> 1) == '0)
  // A tick that does not boost leaves the count below the interval.
  `MLFQ_ASSERT_NXT(a_tick_below_interval, cmd.exec && is_tick && !boost_fire,
                   tick_r < bi_r)

endmodule

/* bench/tb_top.sv */
module tb_top;
  import mlfq_pkg::*;

  // Scheduler geometry as instantiated (the default parameters).
  localparam int NUM_LEVELS  = 3;
  localparam int NUM_THREADS = 32;
  localparam logic [PRIO_W-1:0] LAST_LEVEL = 2'd2;

  // The fourth function code is unused; the block must answer it with all zeros.
  localparam logic [1:0] FUNC_NOP = 2'd3;

  // Cycles without any beat on any channel before the run is declared hung.
  // A boosting tick walks at most 32 threads, one link memory read per hop, and
  // the sender's random gaps are short, so this is many times the slowest case.
  localparam int WATCHDOG_LIMIT = 5000;

  // Cycles to keep watching after the last expected result, for stray beats.
  localparam int TAIL_CYCLES = 150;

  typedef enum logic [1:0] {
    STEP_CMD,    // present one command beat
    STEP_CFG,    // write the boost interval once the block is idle
    STEP_DRAIN,  // hold off until every result is back, then leave a gap of arg
    STEP_RATE    // sender idle percentage from here on
  } step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    in_t         cmd;
    logic [31:0] arg;
  } plan_step_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_t              in_data = '0;
  logic             out_valid;
  out_t             out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  mlfq_thread_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Synchronous reset, applied once at the start of the run.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow state. The ready lists are kept as head, tail and link
  // tables, exactly like the block, so that a boost splices whole lists and
  // keeps their order. A per-level live bit guards every list read.
  // ---------------------------------------------------------------------------
  logic [PRIO_W-1:0] thread_prio [NUM_THREADS];
  logic              is_ready    [NUM_THREADS];
  logic [TID_W-1:0]  ready_link  [NUM_THREADS];
  logic [TID_W-1:0]  ready_head  [NUM_LEVELS];
  logic [TID_W-1:0]  ready_tail  [NUM_LEVELS];
  logic              ready_live  [NUM_LEVELS];
  logic [CNT_W-1:0]  tick_ctr;
  logic [CNT_W-1:0]  boost_every;
  logic [TID_W-1:0]  last_popped;

  out_t       sched_out_q [$];  // answers still owed by the block, oldest first
  plan_step_t cmd_plan    [$];  // work still to be presented by the driver

  int issued;      // commands accepted (driver only)
  int retired;     // results matched against an answer (monitor only, NBA)
  int errors;
  int hits_seen;
  int boosts_seen;
  int cfg_writes;
  int idle_pct;
  int gap_left;
  int quiet;

  // Applies one accepted command to the shadow state and returns the answer.
  function automatic out_t sched_apply(in_t c);
    out_t             r;
    logic [TID_W-1:0] node;
    logic             walk_done;
    int               lvl;
    int               steps;
    r = '0;
    case (c.func)
      FUNC_ENQ: begin
        // A thread that is already on a ready list is ignored outright,
        // including any new priority it carries.
        if (!is_ready[c.thread_id]) begin
          if (c.set_priority) thread_prio[c.thread_id] = c.new_priority;
          if (thread_prio[c.thread_id] > LAST_LEVEL) thread_prio[c.thread_id] = LAST_LEVEL;
          lvl = int'(thread_prio[c.thread_id]);
          if (ready_live[lvl]) begin
            ready_link[ready_tail[lvl]] = c.thread_id;
          end else begin
            ready_head[lvl] = c.thread_id;
            ready_live[lvl] = 1'b1;
          end
          ready_tail[lvl] = c.thread_id;
          is_ready[c.thread_id] = 1'b1;
        end
      end
      FUNC_DEQ: begin
        for (lvl = 0; lvl < NUM_LEVELS && !r.found; lvl++) begin
          if (ready_live[lvl]) begin
            node = ready_head[lvl];
            if (node == ready_tail[lvl]) ready_live[lvl] = 1'b0;
            else ready_head[lvl] = ready_link[node];
            is_ready[node] = 1'b0;
            r.out_thread = node;
            r.found = 1'b1;
            last_popped = node;
          end
        end
      end
      FUNC_TICK: begin
        // Thread 0 is never demoted; the others sink one level per tick.
        if (c.current_valid && c.current_id != '0 && thread_prio[c.current_id] < LAST_LEVEL)
          thread_prio[c.current_id] = thread_prio[c.current_id] + 1'b1;
        tick_ctr = tick_ctr + 1'b1;
        // Compared with at-or-above, so a zero or freshly lowered interval
        // boosts on the very next tick.
        if (tick_ctr >= boost_every) begin
          tick_ctr = '0;
          if (c.current_valid) thread_prio[c.current_id] = '0;
          for (lvl = 1; lvl < NUM_LEVELS; lvl++) begin
            if (ready_live[lvl]) begin
              node = ready_head[lvl];
              walk_done = 1'b0;
              for (steps = 0; steps < NUM_THREADS && !walk_done; steps++) begin
                thread_prio[node] = '0;
                if (node == ready_tail[lvl]) walk_done = 1'b1;
                else node = ready_link[node];
              end
              if (ready_live[0]) ready_link[ready_tail[0]] = ready_head[lvl];
              else ready_head[0] = ready_head[lvl];
              ready_tail[0] = ready_tail[lvl];
              ready_live[0] = 1'b1;
              ready_live[lvl] = 1'b0;
            end
          end
          r.boosted = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_t cmd_of(logic [1:0] func, logic [TID_W-1:0] tid, logic setp,
                                 logic [PRIO_W-1:0] newp, logic cvalid,
                                 logic [TID_W-1:0] cid);
    in_t c;
    c.func          = func;
    c.thread_id     = tid;
    c.set_priority  = setp;
    c.new_priority  = newp;
    c.current_valid = cvalid;
    c.current_id    = cid;
    return c;
  endfunction

  function automatic void push_step(step_kind_t kind, int arg, in_t cmd);
    plan_step_t s;
    s.kind = kind;
    s.cmd  = cmd;
    s.arg  = arg;
    cmd_plan.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. Every handshake that completes at this edge is retired first, and
  // the next value of each strobe is decided once, so start can stay high
  // across back-to-back commands without being dropped and raised again.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic nxt_start;
    logic nxt_cfg;
    if (!rst_n) begin
      start       <= 1'b0;
      cfg_valid   <= 1'b0;
      boost_every = BOOST_RESET;
      tick_ctr    = '0;
      last_popped = '0;
      idle_pct    = 0;
      gap_left    = 0;
      issued      = 0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        thread_prio[i] = '0;
        is_ready[i]    = 1'b0;
        ready_link[i]  = '0;
      end
      for (int l = 0; l < NUM_LEVELS; l++) begin
        ready_head[l] = '0;
        ready_tail[l] = '0;
        ready_live[l] = 1'b0;
      end
    end else begin
      nxt_start = start;
      nxt_cfg   = cfg_valid;
      if (start && !busy) begin
        sched_out_q.push_back(sched_apply(in_data));
        issued++;
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        boost_every = cfg_data;
        cfg_writes++;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_plan.size() > 0) begin
          case (cmd_plan[0].kind)
            STEP_CMD: begin
              if ($urandom_range(99) >= idle_pct) begin
                in_data   <= cmd_plan[0].cmd;
                nxt_start = 1'b1;
                void'(cmd_plan.pop_front());
              end
            end
            STEP_CFG: begin
              // The interval is only changed with nothing in flight.
              if (issued == retired) begin
                cfg_data <= cmd_plan[0].arg[CNT_W-1:0];
                nxt_cfg  = 1'b1;
                void'(cmd_plan.pop_front());
              end
            end
            STEP_DRAIN: begin
              if (issued == retired) begin
                gap_left = cmd_plan[0].arg;
                void'(cmd_plan.pop_front());
              end
            end
            default: begin
              idle_pct = cmd_plan[0].arg;
              void'(cmd_plan.pop_front());
            end
          endcase
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each result beat is compared with the oldest owed answer. The
  // retired count moves by nonblocking assignment so that the driver always
  // sees the value from before this edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    out_t want;
    if (rst_n && out_valid) begin
      if (sched_out_q.size() == 0) begin
        $error("result beat with no command outstanding: out_thread %0d found %0d boosted %0d",
               out_data.out_thread, out_data.found, out_data.boosted);
        errors++;
      end else begin
        want = sched_out_q.pop_front();
        if (out_data.out_thread !== want.out_thread) begin
          $error("out_thread: expected %0d, actual %0d", want.out_thread, out_data.out_thread);
          errors++;
        end
        if (out_data.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_data.found);
          errors++;
        end
        if (out_data.boosted !== want.boosted) begin
          $error("boosted: expected %0d, actual %0d", want.boosted, out_data.boosted);
          errors++;
        end
        if (want.found) hits_seen++;
        if (want.boosted) boosts_seen++;
        retired <= retired + 1;
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles, %0d results outstanding.",
               quiet, sched_out_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus. A short directed opening, then six random phases, each with its
  // own boost interval and one of three sender idle rates. Random commands are
  // generated just ahead of the driver, on the falling edge, so that they can
  // look at which threads are currently ready and keep most enqueues meaningful.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_t c;
    int  phase;
    int  n;
    int  k;
    int  pick;
    int  depth;
    int  enq_cut;
    int  phase_len;
    logic [TID_W-1:0] tid;

    retired     = 0;
    errors      = 0;
    hits_seen   = 0;
    boosts_seen = 0;
    cfg_writes  = 0;
    quiet       = 0;

    push_step(STEP_RATE, 20, '0);
    // Empty queues, a tick with nobody running, and the unused code with
    // every other bit set.
    push_step(STEP_CMD, 0, cmd_of(FUNC_DEQ, 5'd31, 1'b1, 2'd3, 1'b1, 5'd31));
    push_step(STEP_CMD, 0, cmd_of(FUNC_TICK, 5'd0, 1'b0, 2'd0, 1'b0, 5'd31));
    push_step(STEP_CMD, 0, cmd_of(FUNC_NOP, 5'd31, 1'b1, 2'd3, 1'b1, 5'd31));
    // Fill all three levels; priority 3 must saturate to the lowest level.
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd0, 1'b1, 2'd0, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd31, 1'b1, 2'd3, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd5, 1'b1, 2'd2, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd6, 1'b1, 2'd1, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd7, 1'b0, 2'd3, 1'b0, 5'd0));
    // Re-enqueue of a ready thread is ignored, new priority included.
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd31, 1'b1, 2'd0, 1'b0, 5'd0));
    // Thread 0 is never demoted; the lowest level does not sink further.
    push_step(STEP_CMD, 0, cmd_of(FUNC_TICK, 5'd0, 1'b0, 2'd0, 1'b1, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_TICK, 5'd0, 1'b0, 2'd0, 1'b1, 5'd31));
    push_step(STEP_CMD, 0, cmd_of(FUNC_TICK, 5'd0, 1'b0, 2'd0, 1'b1, 5'd6));
    // Drain everything in priority order, then one dequeue past empty.
    for (k = 0; k < 6; k++)
      push_step(STEP_CMD, 0, cmd_of(FUNC_DEQ, 5'd0, 1'b0, 2'd0, 1'b0, 5'd0));
    // Stored levels survive a dequeue when no new priority is given.
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd6, 1'b0, 2'd0, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd31, 1'b0, 2'd1, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd1, 1'b1, 2'd1, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_TICK, 5'd0, 1'b0, 2'd0, 1'b1, 5'd1));
    push_step(STEP_CMD, 0, cmd_of(FUNC_ENQ, 5'd2, 1'b1, 2'd0, 1'b0, 5'd0));
    push_step(STEP_CMD, 0, cmd_of(FUNC_DEQ, 5'd0, 1'b0, 2'd0, 1'b0, 5'd0));

    for (phase = 0; phase < 6; phase++) begin
      // Phase zero runs on the reset interval. After it come the two
      // extremes, a lowered interval that the accumulated tick count already
      // exceeds, zero, and a random moderate value.
      if (phase > 0) begin
        push_step(STEP_DRAIN, 8, '0);
        case (phase)
          1:       push_step(STEP_CFG, 1, '0);
          2:       push_step(STEP_CFG, 65535, '0);
          3:       push_step(STEP_CFG, 4, '0);
          4:       push_step(STEP_CFG, 0, '0);
          default: push_step(STEP_CFG, $urandom_range(8, 40), '0);
        endcase
      end
      push_step(STEP_RATE, (phase < 2) ? 20 : (phase < 4) ? 82 : 0, '0);
      case (phase)
        0:       phase_len = 300;
        1:       phase_len = 150;
        2:       phase_len = 200;
        3:       phase_len = 250;
        4:       phase_len = 100;
        default: phase_len = 325;
      endcase

      for (n = 0; n < phase_len; n++) begin
        while (cmd_plan.size() >= 2) @(negedge clk);
        // Halfway through each phase the sender stops until all is back.
        if (n == phase_len / 2) push_step(STEP_DRAIN, $urandom_range(0, 30), '0);

        depth = 0;
        for (k = 0; k < NUM_THREADS; k++) depth += is_ready[k];
        enq_cut = (depth < 20) ? 45 : 20;

        // Start from random bits so that every field toggles, then shape
        // the fields that the chosen operation uses.
        c    = in_t'(16'($urandom));
        pick = $urandom_range(99);
        if (pick < enq_cut) begin
          tid = 5'($urandom_range(NUM_THREADS - 1));
          for (k = 0; k < NUM_THREADS && is_ready[tid]; k++) tid = tid + 1'b1;
          c.func      = FUNC_ENQ;
          c.thread_id = tid;
        end else if (pick < 72) begin
          c.func = FUNC_DEQ;
        end else if (pick < 94) begin
          c.func = FUNC_TICK;
          if ($urandom_range(9) < 8) begin
            c.current_valid = 1'b1;
            c.current_id    = last_popped;
          end
        end
        // The remaining few percent stay fully random: unused codes,
        // re-enqueues of ready threads and ticks on arbitrary threads.
        push_step(STEP_CMD, 0, c);
      end
    end

    do @(negedge clk); while (cmd_plan.size() != 0 || start || issued != retired);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (sched_out_q.size() != 0) begin
      $error("%0d expected results never arrived", sched_out_q.size());
      errors++;
    end
    $display("Covered %0d commands: %0d successful dequeues, %0d global boosts,",
             issued, hits_seen, boosts_seen);
    $display("%0d interval writes; intervals ran from 0 to 65535 and were lowered %s; %0d errors.",
             cfg_writes, "under a running count", errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
